/* hw/rtl/pnph_pkg.sv */
// Shared constants and codes for the polyline nearest point block.
package pnph_pkg;

    localparam int MAX_NODES_DEF  = 256;
    localparam int COORD_BITS_DEF = 24;
    localparam int MAX_ROPES      = 16;

    localparam int ROPE_W      = 4;
    localparam int LOCAL_W     = 8;
    localparam int ENTRY_W     = 8;
    localparam int CNT_W       = 9;
    localparam int EPOCH_W     = 8;
    localparam int RAD_W       = 23;
    localparam int RAD2_W      = 46;
    localparam int T_W         = 17;
    localparam int OUT_COORD_W = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam int SLOT_AW = ROPE_W + LOCAL_W;
    localparam int SLOT_W  = EPOCH_W + CNT_W;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [T_W-1:0] T_ONE  = 17'd65536;
    localparam logic [T_W-1:0] T_HALF = 17'd32768;

    localparam logic [LOCAL_W-1:0] LOCAL_LAST = 8'hFF;

endpackage

/* hw/rtl/pnph_ram.sv */
// Generic memory with one write port and two registered read ports.
module pnph_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [W-1:0]             rdata0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [W-1:0]             rdata1
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

/* hw/rtl/pnph_front.sv */
// Request front end: accepts items, normalizes them and fills the queue.
module pnph_front #(
    parameter int MAX_NODES  = pnph_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = pnph_pkg::COORD_BITS_DEF,
    parameter int ITEM_W     = 2 + pnph_pkg::ENTRY_W + pnph_pkg::ROPE_W
                               + pnph_pkg::LOCAL_W + 2 * COORD_BITS + pnph_pkg::RAD2_W
) (
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                req_type,
    input  logic [pnph_pkg::ENTRY_W-1:0]        entry,
    input  logic [pnph_pkg::ROPE_W-1:0]         rope_id,
    input  logic [pnph_pkg::LOCAL_W-1:0]        local_index,
    input  logic signed [pnph_pkg::OUT_COORD_W-1:0] pos_x,
    input  logic signed [pnph_pkg::OUT_COORD_W-1:0] pos_y,
    input  logic [pnph_pkg::RAD_W-1:0]          radius,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [ITEM_W-1:0]                   q_data
);

    logic                           wr_ok;
    logic [COORD_BITS-1:0]          cx;
    logic [COORD_BITS-1:0]          cy;
    logic [pnph_pkg::RAD2_W-1:0]    rad2;

    assign wr_ok = int'(entry) < MAX_NODES;
    assign cx    = COORD_BITS'($unsigned(pos_x));
    assign cy    = COORD_BITS'($unsigned(pos_y));
    assign rad2  = radius * radius;

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;
    assign q_data    = {req_type, wr_ok, entry, rope_id, local_index, cx, cy, rad2};

endmodule

/* hw/rtl/pnph_queue.sv */
// Short queue that decouples the front end from the query engine.
module pnph_queue #(
    parameter int W     = 8,
    parameter int DEPTH = pnph_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  store_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full     = count_reg == NW'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/pnph_back.sv */
// Query engine: node store, segment walk, projection divider and result register.
module pnph_back #(
    parameter int MAX_NODES  = pnph_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = pnph_pkg::COORD_BITS_DEF,
    parameter int ITEM_W     = 2 + pnph_pkg::ENTRY_W + pnph_pkg::ROPE_W
                               + pnph_pkg::LOCAL_W + 2 * COORD_BITS + pnph_pkg::RAD2_W
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [pnph_pkg::CNT_W-1:0]           nodes_in_use,
    input  logic                                 q_empty,
    input  logic [ITEM_W-1:0]                    q_data,
    output logic                                 q_pop,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic                                 found,
    output logic [pnph_pkg::ROPE_W-1:0]          hit_rope,
    output logic [pnph_pkg::LOCAL_W-1:0]         hit_segment,
    output logic [pnph_pkg::T_W-1:0]             hit_t,
    output logic [pnph_pkg::LOCAL_W-1:0]         hit_node,
    output logic signed [pnph_pkg::OUT_COORD_W-1:0] hit_x,
    output logic signed [pnph_pkg::OUT_COORD_W-1:0] hit_y
);

    localparam int CB      = COORD_BITS;
    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int NODE_WW = pnph_pkg::ROPE_W + pnph_pkg::LOCAL_W + 2 * CB;
    localparam int MW      = (CB + 2 > 18) ? CB + 2 : 18;
    localparam int PW      = 2 * MW;
    localparam int DW      = (2 * MW + 2 > pnph_pkg::RAD2_W + 1) ? 2 * MW + 2
                                                                 : pnph_pkg::RAD2_W + 1;
    localparam int CW      = pnph_pkg::CNT_W;
    localparam int KEY_W   = pnph_pkg::ROPE_W + pnph_pkg::LOCAL_W;

    localparam int RAD_LSB  = 0;
    localparam int Y_LSB    = RAD_LSB + pnph_pkg::RAD2_W;
    localparam int X_LSB    = Y_LSB + CB;
    localparam int LOC_LSB  = X_LSB + CB;
    localparam int ROPE_LSB = LOC_LSB + pnph_pkg::LOCAL_W;
    localparam int ENT_LSB  = ROPE_LSB + pnph_pkg::ROPE_W;
    localparam int OK_BIT   = ENT_LSB + pnph_pkg::ENTRY_W;
    localparam int TYPE_BIT = OK_BIT + 1;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CLEAR  = 13'b0000000000010,
        ST_BUILD  = 13'b0000000000100,
        ST_FETCH  = 13'b0000000001000,
        ST_SLOT   = 13'b0000000010000,
        ST_CHECK  = 13'b0000000100000,
        ST_LOADB  = 13'b0000001000000,
        ST_MATH   = 13'b0000010000000,
        ST_DIVSET = 13'b0000100000000,
        ST_DIV    = 13'b0001000000000,
        ST_SCALE  = 13'b0010000000000,
        ST_JUDGE  = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic                          q_type;
    logic                          q_wr_ok;
    logic [pnph_pkg::ENTRY_W-1:0]  q_entry;
    logic [pnph_pkg::ROPE_W-1:0]   q_rope;
    logic [pnph_pkg::LOCAL_W-1:0]  q_local;
    logic [CB-1:0]                 q_x;
    logic [CB-1:0]                 q_y;
    logic [pnph_pkg::RAD2_W-1:0]   q_rad2;

    logic start_write;
    logic start_query;
    logic start_clear;
    logic [CW-1:0] n_eff;

    logic                 node_we;
    logic [NODE_AW-1:0]   node_waddr;
    logic [NODE_WW-1:0]   node_wdata;
    logic [NODE_AW-1:0]   node_raddr0;
    logic [NODE_WW-1:0]   node_rdata0;
    logic [NODE_AW-1:0]   node_raddr1;
    logic [NODE_WW-1:0]   node_rdata1;

    logic [pnph_pkg::ROPE_W-1:0]  nd0_rope;
    logic [pnph_pkg::LOCAL_W-1:0] nd0_local;
    logic signed [CB-1:0]         nd0_x;
    logic signed [CB-1:0]         nd0_y;
    logic signed [CB-1:0]         nd1_x;
    logic signed [CB-1:0]         nd1_y;

    logic                          slot_we;
    logic [pnph_pkg::SLOT_AW-1:0]  slot_waddr;
    logic [pnph_pkg::SLOT_W-1:0]   slot_wdata;
    logic [pnph_pkg::SLOT_AW-1:0]  slot_raddr0;
    logic [pnph_pkg::SLOT_W-1:0]   slot_rdata0;
    logic [pnph_pkg::SLOT_AW-1:0]  slot_raddr1;
    logic [pnph_pkg::SLOT_W-1:0]   slot_rdata1;

    logic [pnph_pkg::EPOCH_W-1:0]  epoch_reg;
    logic [pnph_pkg::SLOT_AW-1:0]  clr_reg;
    logic [CW-1:0]                 n_reg;
    logic [CW-1:0]                 bcnt_reg;
    logic                          bld_v_reg;
    logic [CW-1:0]                 bld_e_reg;
    logic [CW-1:0]                 ecnt_reg;
    logic [3:0]                    step_reg;
    logic                          found_reg;
    logic                          rsp_valid_reg;

    logic signed [CB-1:0]          px_reg;
    logic signed [CB-1:0]          py_reg;
    logic [DW-1:0]                 best_reg;
    logic [pnph_pkg::ROPE_W-1:0]   ar_reg;
    logic [pnph_pkg::LOCAL_W-1:0]  ai_reg;
    logic signed [CB-1:0]          ax_reg;
    logic signed [CB-1:0]          ay_reg;
    logic signed [CB:0]            ex_reg;
    logic signed [CB:0]            ey_reg;
    logic signed [CB:0]            qx_reg;
    logic signed [CB:0]            qy_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [DW-1:0]          len2_reg;
    logic signed [DW-1:0]          dot_reg;
    logic [DW-1:0]                 rem_reg;
    logic [15:0]                   q_reg;
    logic [pnph_pkg::T_W-1:0]      t_reg;
    logic signed [CB:0]            hx_reg;
    logic signed [CB:0]            hy_reg;
    logic [DW-1:0]                 d2_reg;

    logic [pnph_pkg::ROPE_W-1:0]   b_rope_reg;
    logic [pnph_pkg::LOCAL_W-1:0]  b_seg_reg;
    logic [pnph_pkg::T_W-1:0]      b_t_reg;
    logic signed [CB:0]            b_hx_reg;
    logic signed [CB:0]            b_hy_reg;

    logic                          rsp_found_reg;
    logic [pnph_pkg::ROPE_W-1:0]   rsp_rope_reg;
    logic [pnph_pkg::LOCAL_W-1:0]  rsp_seg_reg;
    logic [pnph_pkg::T_W-1:0]      rsp_t_reg;
    logic [pnph_pkg::LOCAL_W-1:0]  rsp_node_reg;
    logic signed [pnph_pkg::OUT_COORD_W-1:0] rsp_x_reg;
    logic signed [pnph_pkg::OUT_COORD_W-1:0] rsp_y_reg;

    logic                          bld_issue;
    logic                          seg_ok;
    logic                          last_entry;
    logic signed [MW-1:0]          mul_a;
    logic signed [MW-1:0]          mul_b;
    logic signed [PW-1:0]          scaled;
    logic signed [CB+1:0]          dx;
    logic signed [CB+1:0]          dy;
    logic [DW-1:0]                 rem2;
    logic                          div_ge;
    logic [15:0]                   q_new;
    logic                          better;
    logic [KEY_W-1:0]              cur_key;
    logic [KEY_W-1:0]              best_key;

    assign q_type  = q_data[TYPE_BIT];
    assign q_wr_ok = q_data[OK_BIT];
    assign q_entry = q_data[ENT_LSB +: pnph_pkg::ENTRY_W];
    assign q_rope  = q_data[ROPE_LSB +: pnph_pkg::ROPE_W];
    assign q_local = q_data[LOC_LSB +: pnph_pkg::LOCAL_W];
    assign q_x     = q_data[X_LSB +: CB];
    assign q_y     = q_data[Y_LSB +: CB];
    assign q_rad2  = q_data[RAD_LSB +: pnph_pkg::RAD2_W];

    assign n_eff = (int'(nodes_in_use) > MAX_NODES) ? CW'(MAX_NODES) : nodes_in_use;

    assign start_write = (state_reg == ST_IDLE) && !q_empty && !rsp_valid_reg
                         && (q_type == pnph_pkg::REQ_WRITE);
    assign start_query = (state_reg == ST_IDLE) && !q_empty && !rsp_valid_reg
                         && (q_type == pnph_pkg::REQ_QUERY) && (epoch_reg != '1);
    assign start_clear = (state_reg == ST_IDLE) && !q_empty && !rsp_valid_reg
                         && (q_type == pnph_pkg::REQ_QUERY) && (epoch_reg == '1);
    assign q_pop = start_write || start_query;

    assign node_we     = start_write && q_wr_ok;
    assign node_waddr  = NODE_AW'(q_entry);
    assign node_wdata  = {q_rope, q_local, q_x, q_y};
    assign bld_issue   = (state_reg == ST_BUILD) && (bcnt_reg != '0);
    assign node_raddr0 = (state_reg == ST_BUILD) ? NODE_AW'(bcnt_reg - 1'b1)
                                                 : NODE_AW'(ecnt_reg);
    assign node_raddr1 = NODE_AW'(slot_rdata1[CW-1:0]);

    assign nd0_rope  = node_rdata0[NODE_WW-1 -: pnph_pkg::ROPE_W];
    assign nd0_local = node_rdata0[2*CB +: pnph_pkg::LOCAL_W];
    assign nd0_x     = $signed(node_rdata0[CB +: CB]);
    assign nd0_y     = $signed(node_rdata0[0 +: CB]);
    assign nd1_x     = $signed(node_rdata1[CB +: CB]);
    assign nd1_y     = $signed(node_rdata1[0 +: CB]);

    assign slot_we     = (state_reg == ST_CLEAR)
                         || ((state_reg == ST_BUILD) && bld_v_reg
                             && (int'(nd0_rope) < pnph_pkg::MAX_ROPES));
    assign slot_waddr  = (state_reg == ST_CLEAR) ? clr_reg : {nd0_rope, nd0_local};
    assign slot_wdata  = (state_reg == ST_CLEAR) ? '0 : {epoch_reg, bld_e_reg};
    assign slot_raddr0 = {nd0_rope, nd0_local};
    assign slot_raddr1 = {nd0_rope, nd0_local + 1'b1};

    assign seg_ok = (int'(ar_reg) < pnph_pkg::MAX_ROPES)
                    && (ai_reg != pnph_pkg::LOCAL_LAST)
                    && (slot_rdata0[pnph_pkg::SLOT_W-1 -: pnph_pkg::EPOCH_W] == epoch_reg)
                    && (slot_rdata0[CW-1:0] == ecnt_reg)
                    && (slot_rdata1[pnph_pkg::SLOT_W-1 -: pnph_pkg::EPOCH_W] == epoch_reg);
    assign last_entry = (ecnt_reg + 1'b1) == n_reg;

    assign scaled = (prod_reg + PW'(32768)) >>> 16;
    assign dx     = (CB + 2)'(px_reg) - (CB + 2)'(hx_reg);
    assign dy     = (CB + 2)'(py_reg) - (CB + 2)'(hy_reg);

    assign rem2   = {rem_reg[DW-2:0], 1'b0};
    assign div_ge = rem2 >= $unsigned(len2_reg);
    assign q_new  = {q_reg[14:0], div_ge};

    assign cur_key  = {ar_reg, ai_reg};
    assign best_key = {b_rope_reg, b_seg_reg};
    assign better   = !found_reg ? (d2_reg <= best_reg)
                                 : ((d2_reg < best_reg)
                                    || ((d2_reg == best_reg) && (cur_key > best_key)));

    always_comb
    begin
        mul_a = MW'(ex_reg);
        mul_b = MW'(ex_reg);
        case (state_reg)
            ST_MATH:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = MW'(ex_reg);
                        mul_b = MW'(ex_reg);
                    end
                    4'd1:
                    begin
                        mul_a = MW'(ey_reg);
                        mul_b = MW'(ey_reg);
                    end
                    4'd2:
                    begin
                        mul_a = MW'(ex_reg);
                        mul_b = MW'(qx_reg);
                    end
                    default:
                    begin
                        mul_a = MW'(ey_reg);
                        mul_b = MW'(qy_reg);
                    end
                endcase
            end
            ST_SCALE:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        mul_a = MW'(ex_reg);
                        mul_b = MW'($signed({1'b0, t_reg}));
                    end
                    4'd1:
                    begin
                        mul_a = MW'(ey_reg);
                        mul_b = MW'($signed({1'b0, t_reg}));
                    end
                    4'd3:
                    begin
                        mul_a = MW'(dx);
                        mul_b = MW'(dx);
                    end
                    default:
                    begin
                        mul_a = MW'(dy);
                        mul_b = MW'(dy);
                    end
                endcase
            end
            default:
            begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(ex_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_write)
                begin
                    state_next = ST_OUT;
                end
                else if (start_query)
                begin
                    state_next = ST_BUILD;
                end
                else if (start_clear)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BUILD:
            begin
                if ((bcnt_reg == '0) && !bld_v_reg)
                begin
                    state_next = (n_reg == '0) ? ST_OUT : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SLOT;
            end
            ST_SLOT:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (seg_ok)
                begin
                    state_next = ST_LOADB;
                end
                else
                begin
                    state_next = last_entry ? ST_OUT : ST_FETCH;
                end
            end
            ST_LOADB:
            begin
                state_next = ST_MATH;
            end
            ST_MATH:
            begin
                if (step_reg == 4'd4)
                begin
                    state_next = ST_DIVSET;
                end
            end
            ST_DIVSET:
            begin
                if ((len2_reg == '0) || dot_reg[DW-1] || (dot_reg == '0)
                    || (dot_reg >= len2_reg))
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == 4'd15)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (step_reg == 4'd5)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                state_next = last_entry ? ST_OUT : ST_FETCH;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            epoch_reg     <= '0;
            clr_reg       <= '0;
            bcnt_reg      <= '0;
            bld_v_reg     <= 1'b0;
            ecnt_reg      <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? 4'd0 : step_reg + 1'b1;
            bld_v_reg <= bld_issue;
            if (start_clear)
            begin
                epoch_reg <= '0;
                clr_reg   <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (start_query)
            begin
                epoch_reg <= epoch_reg + 1'b1;
                bcnt_reg  <= n_eff;
            end
            else if (bld_issue)
            begin
                bcnt_reg <= bcnt_reg - 1'b1;
            end
            if (start_write || start_query)
            begin
                found_reg <= 1'b0;
            end
            else if ((state_reg == ST_JUDGE) && better)
            begin
                found_reg <= 1'b1;
            end
            if (state_reg == ST_BUILD)
            begin
                ecnt_reg <= '0;
            end
            else if (((state_reg == ST_CHECK) && !seg_ok) || (state_reg == ST_JUDGE))
            begin
                ecnt_reg <= ecnt_reg + 1'b1;
            end
            if (state_reg == ST_OUT)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        bld_e_reg <= bcnt_reg - 1'b1;
        if (start_query)
        begin
            n_reg    <= n_eff;
            px_reg   <= $signed(q_x);
            py_reg   <= $signed(q_y);
            best_reg <= DW'(q_rad2);
        end
        case (state_reg)
            ST_SLOT:
            begin
                ar_reg <= nd0_rope;
                ai_reg <= nd0_local;
                ax_reg <= nd0_x;
                ay_reg <= nd0_y;
            end
            ST_LOADB:
            begin
                ex_reg <= (CB + 1)'(nd1_x) - (CB + 1)'(ax_reg);
                ey_reg <= (CB + 1)'(nd1_y) - (CB + 1)'(ay_reg);
                qx_reg <= (CB + 1)'(px_reg) - (CB + 1)'(ax_reg);
                qy_reg <= (CB + 1)'(py_reg) - (CB + 1)'(ay_reg);
            end
            ST_MATH:
            begin
                case (step_reg)
                    4'd1:    len2_reg <= DW'(prod_reg);
                    4'd2:    len2_reg <= len2_reg + DW'(prod_reg);
                    4'd3:    dot_reg  <= DW'(prod_reg);
                    4'd4:    dot_reg  <= dot_reg + DW'(prod_reg);
                    default: len2_reg <= len2_reg;
                endcase
            end
            ST_DIVSET:
            begin
                rem_reg <= $unsigned(dot_reg);
                q_reg   <= '0;
                if ((len2_reg == '0) || dot_reg[DW-1] || (dot_reg == '0))
                begin
                    t_reg <= '0;
                end
                else if (dot_reg >= len2_reg)
                begin
                    t_reg <= pnph_pkg::T_ONE;
                end
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? rem2 - $unsigned(len2_reg) : rem2;
                q_reg   <= q_new;
                if (step_reg == 4'd15)
                begin
                    t_reg <= {1'b0, q_new};
                end
            end
            ST_SCALE:
            begin
                case (step_reg)
                    4'd1:    hx_reg <= (CB + 1)'(PW'(ax_reg) + scaled);
                    4'd2:    hy_reg <= (CB + 1)'(PW'(ay_reg) + scaled);
                    4'd4:    d2_reg <= DW'($unsigned(prod_reg));
                    4'd5:    d2_reg <= d2_reg + DW'($unsigned(prod_reg));
                    default: d2_reg <= d2_reg;
                endcase
            end
            ST_JUDGE:
            begin
                if (better)
                begin
                    best_reg   <= d2_reg;
                    b_rope_reg <= ar_reg;
                    b_seg_reg  <= ai_reg;
                    b_t_reg    <= t_reg;
                    b_hx_reg   <= hx_reg;
                    b_hy_reg   <= hy_reg;
                end
            end
            ST_OUT:
            begin
                rsp_found_reg <= found_reg;
                if (found_reg)
                begin
                    rsp_rope_reg <= b_rope_reg;
                    rsp_seg_reg  <= b_seg_reg;
                    rsp_t_reg    <= b_t_reg;
                    rsp_node_reg <= (b_t_reg < pnph_pkg::T_HALF) ? b_seg_reg
                                                                 : b_seg_reg + 1'b1;
                    rsp_x_reg    <= pnph_pkg::OUT_COORD_W'(b_hx_reg);
                    rsp_y_reg    <= pnph_pkg::OUT_COORD_W'(b_hy_reg);
                end
                else
                begin
                    rsp_rope_reg <= '0;
                    rsp_seg_reg  <= '0;
                    rsp_t_reg    <= '0;
                    rsp_node_reg <= '0;
                    rsp_x_reg    <= '0;
                    rsp_y_reg    <= '0;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    pnph_ram #(
        .W     (NODE_WW),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk    (clk),
        .we     (node_we),
        .waddr  (node_waddr),
        .wdata  (node_wdata),
        .raddr0 (node_raddr0),
        .rdata0 (node_rdata0),
        .raddr1 (node_raddr1),
        .rdata1 (node_rdata1)
    );

    pnph_ram #(
        .W     (pnph_pkg::SLOT_W),
        .DEPTH (1 << pnph_pkg::SLOT_AW)
    ) u_slot_ram (
        .clk    (clk),
        .we     (slot_we),
        .waddr  (slot_waddr),
        .wdata  (slot_wdata),
        .raddr0 (slot_raddr0),
        .rdata0 (slot_rdata0),
        .raddr1 (slot_raddr1),
        .rdata1 (slot_rdata1)
    );

    assign rsp_valid   = rsp_valid_reg;
    assign found       = rsp_found_reg;
    assign hit_rope    = rsp_rope_reg;
    assign hit_segment = rsp_seg_reg;
    assign hit_t       = rsp_t_reg;
    assign hit_node    = rsp_node_reg;
    assign hit_x       = rsp_x_reg;
    assign hit_y       = rsp_y_reg;

endmodule

/* hw/rtl/polyline_nearest_point_hit.sv */
// Top level of the polyline nearest point block.
// A write item passes from the queue through the output state to its result. A query item first
// indexes the node store by rope and node number, one entry per cycle, then visits every
// stored entry through the fetch, slot and check states and runs each real segment through
// the shared multiplier and, unless the projection is clamped, the 16-step projection
// divider. After reset, and again after every 255 queries, a clearing pass sweeps all 4096
// entries of the rope index while no item is started; items are still accepted into the
// two-entry queue during that time.
module polyline_nearest_point_hit #(
    parameter int MAX_NODES  = pnph_pkg::MAX_NODES_DEF,
    parameter int COORD_BITS = pnph_pkg::COORD_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [pnph_pkg::CNT_W-1:0]               cfg_wdata,
    input  logic                                     req_valid,
    output logic                                     req_stall,
    input  logic                                     req_type,
    input  logic [pnph_pkg::ENTRY_W-1:0]             entry,
    input  logic [pnph_pkg::ROPE_W-1:0]              rope_id,
    input  logic [pnph_pkg::LOCAL_W-1:0]             local_index,
    input  logic signed [pnph_pkg::OUT_COORD_W-1:0]  pos_x,
    input  logic signed [pnph_pkg::OUT_COORD_W-1:0]  pos_y,
    input  logic [pnph_pkg::RAD_W-1:0]               radius,
    output logic                                     rsp_valid,
    input  logic                                     rsp_stall,
    output logic                                     found,
    output logic [pnph_pkg::ROPE_W-1:0]              hit_rope,
    output logic [pnph_pkg::LOCAL_W-1:0]             hit_segment,
    output logic [pnph_pkg::T_W-1:0]                 hit_t,
    output logic [pnph_pkg::LOCAL_W-1:0]             hit_node,
    output logic signed [pnph_pkg::OUT_COORD_W-1:0]  hit_x,
    output logic signed [pnph_pkg::OUT_COORD_W-1:0]  hit_y
);

    localparam int ITEM_W = 2 + pnph_pkg::ENTRY_W + pnph_pkg::ROPE_W + pnph_pkg::LOCAL_W
                            + 2 * COORD_BITS + pnph_pkg::RAD2_W;

    logic [pnph_pkg::CNT_W-1:0] nodes_in_use_reg;
    logic                       q_push;
    logic [ITEM_W-1:0]          q_push_data;
    logic                       q_full;
    logic                       q_pop;
    logic [ITEM_W-1:0]          q_pop_data;
    logic                       q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            nodes_in_use_reg <= cfg_wdata;
        end
    end

    pnph_front #(
        .MAX_NODES  (MAX_NODES),
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .entry       (entry),
        .rope_id     (rope_id),
        .local_index (local_index),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .radius      (radius),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    pnph_queue #(
        .W     (ITEM_W),
        .DEPTH (pnph_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    pnph_back #(
        .MAX_NODES  (MAX_NODES),
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .nodes_in_use (nodes_in_use_reg),
        .q_empty      (q_empty),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .found        (found),
        .hit_rope     (hit_rope),
        .hit_segment  (hit_segment),
        .hit_t        (hit_t),
        .hit_node     (hit_node),
        .hit_x        (hit_x),
        .hit_y        (hit_y)
    );

    // A miss carries an all-zero result.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> hit_rope == '0 && hit_t == '0 && hit_x == '0 && hit_y == '0)
        else $error("miss result carries nonzero fields");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> hit_t <= pnph_pkg::T_ONE)
        else $error("hit position beyond segment end");

    a_near_node: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found && hit_t < pnph_pkg::T_HALF |-> hit_node == hit_segment)
        else $error("nearer node does not match segment start");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

endmodule

/* bench/tb_polyline_nearest_point_hit.sv */
// Testbench for polyline_nearest_point_hit: node writes and point queries against a predictor.
`timescale 1ns / 1ps

module tb_polyline_nearest_point_hit;

    typedef struct packed {
        logic                               kind;
        logic [pnph_pkg::ENTRY_W-1:0]       entry;
        logic [pnph_pkg::ROPE_W-1:0]        rope;
        logic [pnph_pkg::LOCAL_W-1:0]       local_idx;
        logic signed [23:0]                 x;
        logic signed [23:0]                 y;
        logic [pnph_pkg::RAD_W-1:0]         rad;
    } req_t;

    typedef struct packed {
        logic                               found;
        logic [pnph_pkg::ROPE_W-1:0]        rope;
        logic [pnph_pkg::LOCAL_W-1:0]       segment;
        logic [pnph_pkg::T_W-1:0]           t;
        logic [pnph_pkg::LOCAL_W-1:0]       node;
        logic signed [23:0]                 x;
        logic signed [23:0]                 y;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [pnph_pkg::CNT_W-1:0] cfg_wdata = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic req_type = pnph_pkg::REQ_WRITE;
    logic [pnph_pkg::ENTRY_W-1:0] entry = '0;
    logic [pnph_pkg::ROPE_W-1:0] rope_id = '0;
    logic [pnph_pkg::LOCAL_W-1:0] local_index = '0;
    logic signed [23:0] pos_x = '0;
    logic signed [23:0] pos_y = '0;
    logic [pnph_pkg::RAD_W-1:0] radius = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b1;
    logic found;
    logic [pnph_pkg::ROPE_W-1:0] hit_rope;
    logic [pnph_pkg::LOCAL_W-1:0] hit_segment;
    logic [pnph_pkg::T_W-1:0] hit_t;
    logic [pnph_pkg::LOCAL_W-1:0] hit_node;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;

    req_t    pending_items[$];
    result_t expected_hits[$];

    logic signed [23:0]           node_x[256];
    logic signed [23:0]           node_y[256];
    logic [pnph_pkg::ROPE_W-1:0]  node_rope[256];
    logic [pnph_pkg::LOCAL_W-1:0] node_local[256];
    int nodes_cfg = 0;

    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int gap = 0;
    logic req_taken = 1'b0;

    polyline_nearest_point_hit i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
        .entry(entry), .rope_id(rope_id), .local_index(local_index),
        .pos_x(pos_x), .pos_y(pos_y), .radius(radius),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .found(found),
        .hit_rope(hit_rope), .hit_segment(hit_segment), .hit_t(hit_t),
        .hit_node(hit_node), .hit_x(hit_x), .hit_y(hit_y)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t nearest_hit(req_t q);
        result_t res;
        int slot[4096];
        int n, a, b, s;
        longint px, py, x0, y0, ex, ey, qx, qy, len2, dot, t, hx, hy, dx, dy, d2, best;
        logic [127:0] num;
        res = '0;
        if (q.kind == pnph_pkg::REQ_WRITE)
            return res;
        px = q.x;
        py = q.y;
        best = longint'(q.rad) * longint'(q.rad);
        n = nodes_cfg > 256 ? 256 : nodes_cfg;
        foreach (slot[k])
            slot[k] = 0;
        for (int e = 0; e < n; e++)
        begin
            s = node_rope[e] * 256 + node_local[e];
            if (slot[s] == 0)
                slot[s] = e + 1;
        end
        for (int r = 0; r < pnph_pkg::MAX_ROPES; r++)
        begin
            for (int i = 0; i < 255; i++)
            begin
                a = slot[r * 256 + i];
                b = slot[r * 256 + i + 1];
                if (a == 0 || b == 0)
                    continue;
                x0 = node_x[a - 1];
                y0 = node_y[a - 1];
                ex = longint'(node_x[b - 1]) - x0;
                ey = longint'(node_y[b - 1]) - y0;
                qx = px - x0;
                qy = py - y0;
                len2 = ex * ex + ey * ey;
                dot = ex * qx + ey * qy;
                if (len2 == 0 || dot <= 0)
                    t = 0;
                else if (dot >= len2)
                    t = 65536;
                else
                begin
                    num = 128'(dot) << 16;
                    t = longint'(num / 128'(len2));
                end
                hx = x0 + ((ex * t + 32768) >>> 16);
                hy = y0 + ((ey * t + 32768) >>> 16);
                dx = px - hx;
                dy = py - hy;
                d2 = dx * dx + dy * dy;
                if (d2 > best)
                    continue;
                best = d2;
                res.found = 1'b1;
                res.rope = pnph_pkg::ROPE_W'(r);
                res.segment = pnph_pkg::LOCAL_W'(i);
                res.t = pnph_pkg::T_W'(t);
                res.node = pnph_pkg::LOCAL_W'((t < 32768) ? i : i + 1);
                res.x = 24'(hx);
                res.y = 24'(hy);
            end
        end
        return res;
    endfunction

    function automatic int next_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [23:0] rand_coord();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80)
            return 24'($urandom_range(0, 4095) - 2048);
        if (p < 92)
            return 24'($urandom);
        return ($urandom_range(0, 1) == 1) ? 24'sh7FFFFF : 24'sh800000;
    endfunction

    function automatic req_t random_item();
        req_t q;
        int p;
        q = '0;
        q.x = rand_coord();
        q.y = rand_coord();
        if ($urandom_range(0, 99) < 35)
        begin
            q.kind = pnph_pkg::REQ_WRITE;
            q.entry = pnph_pkg::ENTRY_W'(($urandom_range(0, 4) != 0 && nodes_cfg > 0) ?
                      $urandom_range(0, (nodes_cfg > 256 ? 256 : nodes_cfg) - 1) :
                      $urandom_range(0, 255));
            q.rope = pnph_pkg::ROPE_W'(($urandom_range(0, 9) != 0) ? $urandom_range(0, 3)
                                                                   : $urandom_range(0, 15));
            q.local_idx = pnph_pkg::LOCAL_W'(($urandom_range(0, 9) != 0) ?
                          $urandom_range(0, 7) : $urandom_range(0, 255));
            q.rad = pnph_pkg::RAD_W'($urandom);
        end
        else
        begin
            q.kind = pnph_pkg::REQ_QUERY;
            q.entry = pnph_pkg::ENTRY_W'($urandom);
            q.rope = pnph_pkg::ROPE_W'($urandom);
            q.local_idx = pnph_pkg::LOCAL_W'($urandom);
            p = $urandom_range(0, 99);
            if (p < 60)
                q.rad = pnph_pkg::RAD_W'($urandom_range(0, 4096));
            else if (p < 75)
                q.rad = 23'h7FFFFF;
            else if (p < 85)
                q.rad = '0;
            else
                q.rad = pnph_pkg::RAD_W'($urandom);
        end
        return q;
    endfunction

    function automatic req_t make_write(int e, int r, int l, int x, int y);
        req_t q;
        q = '0;
        q.kind = pnph_pkg::REQ_WRITE;
        q.entry = pnph_pkg::ENTRY_W'(e);
        q.rope = pnph_pkg::ROPE_W'(r);
        q.local_idx = pnph_pkg::LOCAL_W'(l);
        q.x = 24'(x);
        q.y = 24'(y);
        return q;
    endfunction

    function automatic req_t make_query(int x, int y, int rad);
        req_t q;
        q = '0;
        q.kind = pnph_pkg::REQ_QUERY;
        q.x = 24'(x);
        q.y = 24'(y);
        q.rad = pnph_pkg::RAD_W'(rad);
        return q;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || req_valid || expected_hits.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_nodes(int v);
        wait_idle();
        cfg_wdata <= pnph_pkg::CNT_W'(v);
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        nodes_cfg = v;
    endtask

    always @(posedge clk)
    begin
        req_t q;
        req_taken <= req_valid && !req_stall;
        if (rst_n && req_valid && !req_stall)
        begin
            q.kind = req_type;
            q.entry = entry;
            q.rope = rope_id;
            q.local_idx = local_index;
            q.x = pos_x;
            q.y = pos_y;
            q.rad = radius;
            expected_hits.push_back(nearest_hit(q));
            if (q.kind == pnph_pkg::REQ_WRITE)
            begin
                node_x[q.entry] = q.x;
                node_y[q.entry] = q.y;
                node_rope[q.entry] = q.rope;
                node_local[q.entry] = q.local_idx;
            end
        end
    end

    always @(negedge clk)
    begin
        req_t q;
        if (!req_valid || req_taken)
        begin
            if (gap > 0)
            begin
                gap = gap - 1;
                req_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                q = pending_items.pop_front();
                req_type <= q.kind;
                entry <= q.entry;
                rope_id <= q.rope;
                local_index <= q.local_idx;
                pos_x <= q.x;
                pos_y <= q.y;
                radius <= q.rad;
                req_valid <= 1'b1;
                gap = next_gap();
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got = '{found, hit_rope, hit_segment, hit_t, hit_node, hit_x, hit_y};
            if (expected_hits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, actual %p", $realtime, got);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch, expected %p actual %p", $realtime, want, got);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = 800;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            stall_left = next_gap();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int sizes[11];
        int count;
        sizes = '{16, 4, 0, 32, 1, 2, 256, 511, 12, 24, 8};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_nodes(0);
        pending_items.push_back(make_query(0, 0, 23'h7FFFFF));
        pending_items.push_back(make_write(0, 0, 0, 0, 0));
        pending_items.push_back(make_write(1, 0, 1, 2560, 0));
        pending_items.push_back(make_write(2, 0, 2, 5120, 0));
        pending_items.push_back(make_write(3, 0, 1, 9999, 9999));
        pending_items.push_back(make_write(4, 1, 5, 1000, 1000));
        pending_items.push_back(make_write(5, 1, 6, 1000, 1000));
        pending_items.push_back(make_write(6, 15, 254, -8388608, -8388608));
        pending_items.push_back(make_write(7, 15, 255, 8388607, 8388607));
        pending_items.push_back(make_write(8, 2, 3, 300, -300));
        pending_items.push_back(make_write(9, 2, 5, 400, -400));
        set_nodes(10);
        pending_items.push_back(make_query(1280, 100, 200));
        pending_items.push_back(make_query(2560, 500, 1000));
        pending_items.push_back(make_query(-500, 0, 600));
        pending_items.push_back(make_query(6000, 0, 2000));
        pending_items.push_back(make_query(1000, 1010, 20));
        pending_items.push_back(make_query(0, 0, 0));
        pending_items.push_back(make_query(8388607, -8388608, 23'h7FFFFF));
        pending_items.push_back(make_query(350, -350, 10));
        pending_items.push_back(make_query(100, 100000, 5));
        pending_items.push_back(make_write(255, 15, 255, 8388607, -8388608));

        for (int e = 10; e < 256; e++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back(make_write(e, $urandom, $urandom, $urandom, $urandom));
            else
                pending_items.push_back(make_write(e, e / 16, e % 16,
                                                   $urandom_range(0, 4095) - 2048,
                                                   $urandom_range(0, 4095) - 2048));
            if ($urandom_range(0, 3) == 0)
                pending_items.push_back(random_item());
        end

        for (int p = 0; p < 11; p++)
        begin
            set_nodes(sizes[p]);
            quiet = (p % 3 == 2);
            count = (sizes[p] >= 256) ? 25 : 100;
            for (int k = 0; k < count; k++)
                pending_items.push_back(random_item());
            if (p == 1)
            begin
                while (pending_items.size() > count - 10)
                    @(negedge clk);
                hold_requests++;
            end
        end

        wait_idle();
        repeat (200) @(negedge clk);
        if (errors == 0 && expected_hits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
